// ===== rtl/core/wsfp_pkg.sv =====
// Package for the WebSocket frame parser: phase, kind and cause codes,
// result word type and length-range helpers. No dependencies.
`timescale 1ns / 1ps

package wsfp_pkg;

  localparam int unsigned LenBits = 32;
  localparam logic [63:0] LenLimit = 64'((65'd1 << LenBits) - 65'd1);
  localparam logic [31:0] LenMask = LenLimit[31:0];

  localparam logic [3:0] OpCont  = 4'h0;
  localparam logic [3:0] OpText  = 4'h1;
  localparam logic [3:0] OpBin   = 4'h2;
  localparam logic [3:0] OpClose = 4'h8;
  localparam logic [3:0] OpPing  = 4'h9;
  localparam logic [3:0] OpPong  = 4'hA;

  localparam logic [6:0] Len16Code = 7'd126;
  localparam logic [6:0] Len64Code = 7'd127;

  typedef enum logic [2:0] {
    PhHdr0    = 3'd0,
    PhHdr1    = 3'd1,
    PhExt16   = 3'd2,
    PhExt64   = 3'd3,
    PhKey     = 3'd4,
    PhPayload = 3'd5,
    PhDrop    = 3'd6
  } phase_e;

  typedef enum logic [2:0] {
    KindCont  = 3'd0,
    KindText  = 3'd1,
    KindBin   = 3'd2,
    KindClose = 3'd3,
    KindPing  = 3'd4,
    KindPong  = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    CauseNone   = 3'd0,
    CauseOpcode = 3'd1,
    CauseHigh   = 3'd2,
    CauseLong   = 3'd3,
    CauseTrunc  = 3'd4
  } cause_e;

  typedef enum logic [2:0] {
    ActNone,
    ActData,
    ActLast,
    ActEmpty,
    ActError
  } act_e;

  typedef struct packed {
    logic        valid;
    logic [7:0]  payload_byte;
    logic        byte_valid;
    logic [2:0]  frame_kind;
    logic [31:0] payload_length;
    logic        error_flag;
    logic [2:0]  error_cause;
    logic        frame_end;
  } result_t;

  // Byte k of the 64-bit length field carries bits 8*(7-k)+7 down to 8*(7-k).
  function automatic logic len_byte_too_high(logic [2:0] k, logic [7:0] b);
    logic [5:0] p;
    logic [7:0] allowed;
    p = {3'(3'd7 - k), 3'b000};
    allowed = 8'(LenLimit >> p);
    return |(b & ~allowed);
  endfunction

endpackage

// ===== rtl/core/wsfp_parser.sv =====
// Frame parser state machine, mask key store and unmasking datapath.
// Depends on wsfp_pkg.
`timescale 1ns / 1ps

module wsfp_parser (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  logic [7:0]       rx_byte_i,
  input  logic             chunk_end_i,
  input  logic [31:0]      max_len_i,
  output wsfp_pkg::result_t res_o
);
  import wsfp_pkg::*;

  phase_e      phase_q, phase_d;
  kind_e       kind_q, kind_d;
  logic        masked_q, masked_d;
  logic [31:0] len_q, len_d;
  logic [31:0] rem_q, rem_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [1:0]  kpos_q, kpos_d;
  logic [7:0]  key_q [4];

  act_e        act;
  cause_e      cause;
  logic        len_fin;
  logic        pay_start;
  logic [7:0]  unmasked;
  logic [6:0]  len7;

  assign len7 = rx_byte_i[6:0];
  assign unmasked = masked_q ? (rx_byte_i ^ key_q[kpos_q]) : rx_byte_i;

  always_comb begin
    phase_d   = phase_q;
    kind_d    = kind_q;
    masked_d  = masked_q;
    len_d     = len_q;
    rem_d     = rem_q;
    cnt_d     = cnt_q;
    kpos_d    = kpos_q;
    act       = ActNone;
    cause     = CauseNone;
    len_fin   = 1'b0;
    pay_start = 1'b0;
    if (fire_i) begin
      unique case (phase_q)
        PhHdr0: begin
          kind_d   = KindCont;
          masked_d = 1'b0;
          len_d    = '0;
          rem_d    = '0;
          cnt_d    = '0;
          kpos_d   = '0;
          act      = ActNone;
          if (rx_byte_i[7]) begin
            unique case (rx_byte_i[3:0])
              OpText:  kind_d = KindText;
              OpBin:   kind_d = KindBin;
              OpClose: kind_d = KindClose;
              OpPing:  kind_d = KindPing;
              OpPong:  kind_d = KindPong;
              default: act = ActError;
            endcase
          end else if (rx_byte_i[3:0] != OpCont) begin
            act = ActError;
          end
          if (act == ActError) begin
            cause   = CauseOpcode;
            phase_d = chunk_end_i ? PhHdr0 : PhDrop;
          end else if (chunk_end_i) begin
            act     = ActError;
            cause   = CauseTrunc;
            phase_d = PhHdr0;
          end else begin
            phase_d = PhHdr1;
          end
        end
        PhHdr1: begin
          masked_d = rx_byte_i[7];
          cnt_d    = '0;
          if (len7 == Len16Code || len7 == Len64Code) begin
            phase_d = (len7 == Len16Code) ? PhExt16 : PhExt64;
            if (chunk_end_i) begin
              act     = ActError;
              cause   = CauseTrunc;
              phase_d = PhHdr0;
            end
          end else begin
            len_d   = {25'd0, len7};
            len_fin = 1'b1;
          end
        end
        PhExt16: begin
          len_d = {len_q[23:0], rx_byte_i} & LenMask;
          cnt_d = cnt_q + 4'd1;
          if (cnt_q >= 4'd1) begin
            len_fin = 1'b1;
          end else if (chunk_end_i) begin
            act     = ActError;
            cause   = CauseTrunc;
            phase_d = PhHdr0;
          end
        end
        PhExt64: begin
          if (len_byte_too_high(cnt_q[2:0], rx_byte_i)) begin
            act     = ActError;
            cause   = CauseHigh;
            phase_d = chunk_end_i ? PhHdr0 : PhDrop;
          end else begin
            len_d = {len_q[23:0], rx_byte_i} & LenMask;
            cnt_d = cnt_q + 4'd1;
            if (cnt_q >= 4'd7) begin
              len_fin = 1'b1;
            end else if (chunk_end_i) begin
              act     = ActError;
              cause   = CauseTrunc;
              phase_d = PhHdr0;
            end
          end
        end
        PhKey: begin
          cnt_d = cnt_q + 4'd1;
          if (cnt_q >= 4'd3) begin
            pay_start = 1'b1;
          end else if (chunk_end_i) begin
            act     = ActError;
            cause   = CauseTrunc;
            phase_d = PhHdr0;
          end
        end
        PhPayload: begin
          kpos_d = kpos_q + 2'd1;
          rem_d  = rem_q - 32'd1;
          if (rem_d == '0) begin
            act     = ActLast;
            phase_d = chunk_end_i ? PhHdr0 : PhDrop;
          end else if (chunk_end_i) begin
            act     = ActError;
            cause   = CauseTrunc;
            phase_d = PhHdr0;
          end else begin
            act = ActData;
          end
        end
        PhDrop: begin
          if (chunk_end_i) begin
            phase_d = PhHdr0;
          end
        end
        default: phase_d = PhHdr0;
      endcase
      if (len_fin) begin
        if (len_d > max_len_i) begin
          act     = ActError;
          cause   = CauseLong;
          phase_d = chunk_end_i ? PhHdr0 : PhDrop;
        end else if (masked_d) begin
          phase_d = PhKey;
          cnt_d   = '0;
          if (chunk_end_i) begin
            act     = ActError;
            cause   = CauseTrunc;
            phase_d = PhHdr0;
          end
        end else begin
          pay_start = 1'b1;
        end
      end
      if (pay_start) begin
        rem_d  = len_d;
        kpos_d = '0;
        if (len_d == '0) begin
          act     = ActEmpty;
          phase_d = chunk_end_i ? PhHdr0 : PhDrop;
        end else if (chunk_end_i) begin
          act     = ActError;
          cause   = CauseTrunc;
          phase_d = PhHdr0;
        end else begin
          phase_d = PhPayload;
        end
      end
    end
  end

  always_comb begin
    res_o.valid          = (act != ActNone);
    res_o.byte_valid     = (act == ActData) || (act == ActLast);
    res_o.payload_byte   = res_o.byte_valid ? unmasked : 8'h00;
    res_o.frame_kind     = kind_d;
    res_o.payload_length = len_d;
    res_o.error_flag     = (act == ActError);
    res_o.error_cause    = cause;
    res_o.frame_end      = (act == ActLast) || (act == ActEmpty) || (act == ActError);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhHdr0;
      kind_q   <= KindCont;
      masked_q <= 1'b0;
      len_q    <= '0;
      rem_q    <= '0;
      cnt_q    <= '0;
      kpos_q   <= '0;
    end else begin
      phase_q  <= phase_d;
      kind_q   <= kind_d;
      masked_q <= masked_d;
      len_q    <= len_d;
      rem_q    <= rem_d;
      cnt_q    <= cnt_d;
      kpos_q   <= kpos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i && phase_q == PhKey) begin
      key_q[cnt_q[1:0]] <= rx_byte_i;
    end
  end

endmodule

// ===== rtl/core/wsfp_out_reg.sv =====
// Result register for the WebSocket frame parser: holds one result word
// until the consumer takes it. Depends on wsfp_pkg.
`timescale 1ns / 1ps

module wsfp_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  wsfp_pkg::result_t res_i,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  output logic [7:0]        payload_byte_o,
  output logic              byte_valid_o,
  output logic [2:0]        frame_kind_o,
  output logic [31:0]       payload_length_o,
  output logic              error_flag_o,
  output logic [2:0]        error_cause_o,
  output logic              frame_end_o
);
  import wsfp_pkg::*;

  logic    valid_q, valid_d;
  result_t data_q;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = res_i.valid;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && res_i.valid) begin
      data_q <= res_i;
    end
  end

  assign out_valid_o      = valid_q;
  assign payload_byte_o   = data_q.payload_byte;
  assign byte_valid_o     = data_q.byte_valid;
  assign frame_kind_o     = data_q.frame_kind;
  assign payload_length_o = data_q.payload_length;
  assign error_flag_o     = data_q.error_flag;
  assign error_cause_o    = data_q.error_cause;
  assign frame_end_o      = data_q.frame_end;

endmodule

// ===== rtl/core/websocket_frame_parser.sv =====
// WebSocket frame parser, one received byte per clock. An input register takes
// each byte, the header parser and unmasking logic turn it into at most one
// result word, and a result register holds it for the consumer. Sustained rate
// is one byte per cycle unless the output stalls; the input register's result
// is registered, and input stalls only while the result register is full and
// stalled. max_len_q resets to all ones; cfg_ready_o is always high.
// Depends on wsfp_pkg, wsfp_parser and wsfp_out_reg.
`timescale 1ns / 1ps

module websocket_frame_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  input  logic        chunk_end_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  payload_byte_o,
  output logic        byte_valid_o,
  output logic [2:0]  frame_kind_o,
  output logic [31:0] payload_length_o,
  output logic        error_flag_o,
  output logic [2:0]  error_cause_o,
  output logic        frame_end_o
);
  import wsfp_pkg::*;

  logic        in_valid_q, in_valid_d;
  logic [7:0]  byte_q;
  logic        ce_q;
  logic [31:0] max_len_q;
  logic        fire;
  logic        accept;
  result_t     res;

  assign cfg_ready_o = 1'b1;
  assign fire       = in_valid_q && !(out_valid_o && out_stall_i);
  assign in_stall_o = in_valid_q && out_valid_o && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (fire) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      max_len_q  <= '1;
    end else begin
      in_valid_q <= in_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        max_len_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= rx_byte_i;
      ce_q   <= chunk_end_i;
    end
  end

  wsfp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .rx_byte_i   (byte_q),
    .chunk_end_i (ce_q),
    .max_len_i   (max_len_q),
    .res_o       (res)
  );

  wsfp_out_reg u_out_reg (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .load_i           (fire),
    .res_i            (res),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .payload_byte_o   (payload_byte_o),
    .byte_valid_o     (byte_valid_o),
    .frame_kind_o     (frame_kind_o),
    .payload_length_o (payload_length_o),
    .error_flag_o     (error_flag_o),
    .error_cause_o    (error_cause_o),
    .frame_end_o      (frame_end_o)
  );

endmodule

// ===== rtl/core/wsfp_checker.sv =====
// Port-level checks for the WebSocket frame parser and the bind that
// attaches them to websocket_frame_parser. Depends on wsfp_pkg.
`timescale 1ns / 1ps

module wsfp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [7:0]  payload_byte_o,
  input logic        byte_valid_o,
  input logic        error_flag_o,
  input logic [2:0]  error_cause_o,
  input logic        frame_end_o
);
  import wsfp_pkg::*;

  a_err_ends_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_flag_o |-> frame_end_o && !byte_valid_o)
    else $error("error word without frame end or with data");

  a_nodata_ends_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !byte_valid_o |-> frame_end_o && payload_byte_o == 8'h00)
    else $error("word without data is not a clean frame end");

  a_cause_matches_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> error_flag_o == (error_cause_o != CauseNone))
    else $error("error cause disagrees with error flag");

  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(payload_byte_o))
    else $error("stalled word changed");

endmodule

bind websocket_frame_parser wsfp_checker u_wsfp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .payload_byte_o (payload_byte_o),
  .byte_valid_o   (byte_valid_o),
  .error_flag_o   (error_flag_o),
  .error_cause_o  (error_cause_o),
  .frame_end_o    (frame_end_o)
);
